// File: rtl/core/aes_pkg.sv
package aes_pkg;

   localparam int RoundKeyWordsDefault = 60;

   typedef enum logic [2:0] {
      CSR_KEY0 = 3'd0,
      CSR_KEY1 = 3'd1,
      CSR_KEY2 = 3'd2,
      CSR_KEY3 = 3'd3,
      CSR_MODE = 3'd4,
      CSR_DIR  = 3'd5
   } csr_index_type;

   typedef logic [7:0] sbox_table_type [256];

   localparam sbox_table_type FwdSbox = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam sbox_table_type InvSbox = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // forward mix of one column, bytes in row order
   function automatic logic [31:0] mix_col(input logic [31:0] c);
      logic [7:0] a0, a1, a2, a3;
      a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
      mix_col = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                 a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                 a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                 xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
   endfunction

   // inverse mix: premultiply by {05,00,04,00} then forward mix
   function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
      logic [7:0] a0, a1, a2, a3, u, v;
      a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
      u = xtime(xtime(a0 ^ a2));
      v = xtime(xtime(a1 ^ a3));
      inv_mix_col = mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
   endfunction

endpackage

// File: rtl/core/aes_if.sv
interface aes_blk_if;
   logic        valid;
   logic        ready;
   logic [63:0] hi;
   logic [63:0] lo;
   modport source (output valid, hi, lo, input ready);
   modport sink (input valid, hi, lo, output ready);
endinterface

interface aes_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/aes_ram.sv
module aes_ram #(
   parameter int Width = 32,
   parameter int Depth = 60
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: rtl/core/aes_block_cipher_top.sv
// one block at a time: the next input is taken only after the result transfer,
//   so a waiting result holds off input; the first block after reset or a
//   key or key-length write expands the round keys first; the s-box and key
//   paths are byte-serial
// reset: synchronous, clears control and configuration; round-key store not cleared
module aes_block_cipher_top #(
   parameter int RoundKeyWords = aes_pkg::RoundKeyWordsDefault
) (
   input  logic clock,
   input  logic reset,
   aes_blk_if.sink   req,
   aes_blk_if.source rsp,
   aes_csr_if.sink   csr
);
   localparam int AddrW = $clog2(RoundKeyWords);

   typedef enum logic [3:0] {
      IDLE, EXP_RD, EXP_WAIT, EXP_SUB, EXP_WR,
      ARK_RD, ARK_WAIT, ARK_BYTE, SUB_BYTE, SUB_END, MIX_COL, DONE
   } state_type;

   state_type   state_ff;
   logic [63:0] key_ff [4];
   logic [1:0]  mode_ff;
   logic        dir_ff;
   logic        expanded_ff;
   logic [3:0]  rounds_ff;
   // state held as a byte shift line, byte 0 at the top
   logic [127:0] st_ff;
   logic [31:0]  word_ff;      // round key word or expansion temp
   logic [4:0]   bcnt_ff;      // byte count within a pass
   logic [3:0]   round_ff;
   logic [5:0]   widx_ff;      // word index during expansion
   logic [2:0]   wsub_ff;      // word in the current group of nk
   logic [7:0]   rc_ff;
   logic [31:0]  kw_shift_ff [8]; // last nk words during expansion
   logic [127:0] tmp_ff;

   logic [3:0]  nk;
   logic [3:0]  eff_mode_rounds;
   logic [AddrW-1:0] rd_addr;
   logic [1:0]  rd_col;
   logic [31:0] rd_data;
   logic        wr_en;

   // key length, shortened when the store is too small
   always_comb begin
      priority if (mode_ff == 2'd0) begin
         nk = 4'd4;
      end else if (mode_ff == 2'd1) begin
         nk = (RoundKeyWords >= 52) ? 4'd6 : 4'd4;
      end else begin
         nk = (RoundKeyWords >= 60) ? 4'd8 : ((RoundKeyWords >= 52) ? 4'd6 : 4'd4);
      end
      eff_mode_rounds = nk + 4'd6;
   end

   logic [5:0] total;
   assign total = {rounds_ff, 2'b00} + 6'd4;

   aes_ram #(.Width(32), .Depth(RoundKeyWords)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(widx_ff[AddrW-1:0]),
      .wr_data(word_ff),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // address one column ahead, since the read data arrives in the cycle after the address
   always_comb begin
      rd_col = (state_ff == ARK_BYTE) ? bcnt_ff[3:2] + 2'd1 : 2'd0;
      rd_addr = AddrW'({round_ff, 2'b00} + {4'd0, rd_col});
   end
   assign wr_en = (state_ff == EXP_WR);

   assign csr.ready = (state_ff == IDLE);
   assign req.ready = (state_ff == IDLE) && !csr.valid;
   assign rsp.valid = (state_ff == DONE);
   assign rsp.hi = st_ff[127:64];
   assign rsp.lo = st_ff[63:0];

   logic [7:0] sb_in, sb_out;
   assign sb_in = (state_ff == EXP_SUB) ? word_ff[31:24] : st_ff[127:120];
   assign sb_out = (dir_ff && state_ff != EXP_SUB) ?
                   aes_pkg::InvSbox[sb_in] : aes_pkg::FwdSbox[sb_in];

   // position after shift rows for byte index b (column c = b/4, row r = b%4)
   function automatic logic [3:0] shift_pos(input logic [3:0] b, input logic inv);
      logic [1:0] r, c;
      r = b[1:0]; c = b[3:2];
      shift_pos = inv ? {c + r, r} : {c - r, r};
   endfunction

   logic [31:0] mcol;
   assign mcol = dir_ff ? aes_pkg::inv_mix_col(st_ff[127:96])
                        : aes_pkg::mix_col(st_ff[127:96]);

   logic [31:0] new_word;
   always_comb begin
      new_word = kw_shift_ff[0] ^ word_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= IDLE;
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         mode_ff     <= '0;
         dir_ff      <= 1'b0;
         expanded_ff <= 1'b0;
         rounds_ff   <= 4'd10;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (csr.valid) begin
                  unique case (csr.index)
                     aes_pkg::CSR_KEY0: begin key_ff[0] <= csr.data; expanded_ff <= 1'b0; end
                     aes_pkg::CSR_KEY1: begin key_ff[1] <= csr.data; expanded_ff <= 1'b0; end
                     aes_pkg::CSR_KEY2: begin key_ff[2] <= csr.data; expanded_ff <= 1'b0; end
                     aes_pkg::CSR_KEY3: begin key_ff[3] <= csr.data; expanded_ff <= 1'b0; end
                     aes_pkg::CSR_MODE: begin mode_ff <= csr.data[1:0]; expanded_ff <= 1'b0; end
                     aes_pkg::CSR_DIR:  dir_ff <= csr.data[0];
                     default: ;
                  endcase
               end else if (req.valid) begin
                  st_ff <= {req.hi, req.lo};
                  bcnt_ff <= '0;
                  if (!expanded_ff) begin
                     rounds_ff <= eff_mode_rounds;
                     for (int i = 0; i < 4; i++) begin
                        kw_shift_ff[2*i]   <= key_ff[i][63:32];
                        kw_shift_ff[2*i+1] <= key_ff[i][31:0];
                     end
                     widx_ff <= '0;
                     wsub_ff <= '0;
                     rc_ff <= 8'h01;
                     state_ff <= EXP_WR;
                     word_ff <= key_ff[0][63:32];
                  end else begin
                     round_ff <= dir_ff ? rounds_ff : 4'd0;
                     state_ff <= ARK_RD;
                  end
               end
            end
            // expansion: write the first nk words, then derive the rest
            EXP_WR: begin
               widx_ff <= widx_ff + 6'd1;
               if (widx_ff + 6'd1 == total) begin
                  expanded_ff <= 1'b1;
                  round_ff <= dir_ff ? rounds_ff : 4'd0;
                  state_ff <= ARK_RD;
               end else if (widx_ff + 6'd1 < {2'b00, nk}) begin
                  word_ff <= kw_shift_ff[widx_ff[2:0] + 3'd1];
               end else begin
                  if (widx_ff + 6'd1 == {2'b00, nk}) begin
                     // window now holds w[0..nk-1], so slot 0 is already w[i-nk]
                     wsub_ff <= '0;
                  end else begin
                     for (int i = 0; i < 7; i++) kw_shift_ff[i] <= kw_shift_ff[i+1];
                     kw_shift_ff[nk[2:0] - 3'd1] <= word_ff;
                     wsub_ff <= (wsub_ff + 3'd1 == nk[2:0] || (nk == 4'd8 && wsub_ff == 3'd7))
                                ? 3'd0 : wsub_ff + 3'd1;
                  end
                  state_ff <= EXP_RD;
               end
            end
            EXP_RD: begin
               // word_ff holds w[i-1]; prepare transform
               if (wsub_ff == 3'd0) begin
                  word_ff <= {word_ff[23:0], word_ff[31:24]};
                  bcnt_ff <= '0;
                  state_ff <= EXP_SUB;
               end else if (nk == 4'd8 && wsub_ff == 3'd4) begin
                  bcnt_ff <= '0;
                  state_ff <= EXP_SUB;
               end else begin
                  word_ff <= new_word;
                  state_ff <= EXP_WR;
               end
            end
            EXP_SUB: begin
               word_ff <= {word_ff[23:0], sb_out};
               bcnt_ff <= bcnt_ff + 5'd1;
               if (bcnt_ff == 5'd3) begin
                  state_ff <= EXP_WAIT;
               end
            end
            EXP_WAIT: begin
               if (wsub_ff == 3'd0) begin
                  word_ff <= new_word ^ {rc_ff, 24'd0};
                  rc_ff <= aes_pkg::xtime(rc_ff);
               end else begin
                  word_ff <= new_word;
               end
               state_ff <= EXP_WR;
            end
            // key addition, one byte a cycle with the state rotating, pausing to fetch each key column
            ARK_RD: begin
               bcnt_ff <= '0;
               state_ff <= ARK_WAIT;
            end
            ARK_WAIT: begin
               word_ff <= rd_data;
               state_ff <= ARK_BYTE;
            end
            ARK_BYTE: begin
               st_ff <= {st_ff[119:0], st_ff[127:120] ^ word_ff[31:24]};
               word_ff <= {word_ff[23:0], 8'h00};
               bcnt_ff <= bcnt_ff + 5'd1;
               if (bcnt_ff[1:0] == 2'd3) begin
                  if (bcnt_ff == 5'd15) begin
                     bcnt_ff <= '0;
                     if ((!dir_ff && round_ff == rounds_ff) || (dir_ff && round_ff == 4'd0)) begin
                        state_ff <= DONE;
                     end else if (dir_ff && round_ff != rounds_ff) begin
                        state_ff <= MIX_COL;
                     end else begin
                        state_ff <= SUB_BYTE;
                     end
                  end else begin
                     state_ff <= ARK_WAIT;
                  end
               end
            end
            SUB_BYTE: begin
               // substitute and scatter to shifted position
               st_ff <= {st_ff[119:0], 8'h00};
               tmp_ff[{~shift_pos(bcnt_ff[3:0], dir_ff), 3'b111} -: 8] <= sb_out;
               bcnt_ff <= bcnt_ff + 5'd1;
               if (bcnt_ff == 5'd15) begin
                  bcnt_ff <= '0;
                  state_ff <= SUB_END;
               end
            end
            SUB_END: begin
               // last byte has landed, take the shifted state
               st_ff <= tmp_ff;
               if (!dir_ff) begin
                  round_ff <= round_ff + 4'd1;
                  state_ff <= (round_ff + 4'd1 == rounds_ff) ? ARK_RD : MIX_COL;
               end else begin
                  round_ff <= round_ff - 4'd1;
                  state_ff <= ARK_RD;
               end
            end
            MIX_COL: begin
               st_ff <= {st_ff[95:0], mcol};
               bcnt_ff <= bcnt_ff + 5'd4;
               if (bcnt_ff == 5'd12) begin
                  bcnt_ff <= '0;
                  // forward mix goes on to key addition, inverse mix to sub/shift
                  state_ff <= dir_ff ? SUB_BYTE : ARK_RD;
               end
            end
            DONE: begin
               if (rsp.ready) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule
